// ===== sv/qlpt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Q-learning position tuner package
// Shared widths, codes, the sequencer state type and the elaboration-time
// builder for the greedy threshold table.
// ----------------------------------------------------------------------------
package qlpt_pkg;

  // Field widths.
  localparam int PERF_W      = 24;
  localparam int EXPLORE_W   = 7;
  localparam int ACT_DRAW_W  = 3;
  localparam int ACT_W       = 2;
  localparam int POS_OUT_W   = 3;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 1;
  localparam int STEP_W      = 16;
  localparam int Q_W         = 32;

  // Parameter defaults.
  localparam int NUM_POSITIONS_DEF = 8;
  localparam int EXPLORE_STEPS_DEF = 630;

  // Constants of the learning rule.
  localparam logic signed [Q_W-1:0] TABLE_INIT = 32'sd655360;
  localparam logic [CFG_W-1:0] GAMMA_RESET = 16'd26214;
  localparam logic [CFG_W-1:0] ALPHA_RESET = 16'd58982;
  localparam logic [STEP_W-1:0] STEP_MAX = 16'hFFFF;
  localparam logic [STEP_W-1:0] RELOAD_STEP = 16'd2;
  localparam int LN2_Q16     = 45426;
  localparam int DRAW_LIMIT  = 100;

  // Greedy threshold table: one entry per draw value, entries past the
  // last meaningful draw stay zero and are never used.
  localparam int THR_W       = 17;
  localparam int THR_ENTRIES = 128;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_DISCOUNT_GAIN = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEARNING_RATE = 1'd1;

  // Action codes.
  localparam logic [ACT_W-1:0] ACT_STAY = 2'd0;
  localparam logic [ACT_W-1:0] ACT_UP   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_DOWN = 2'd2;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_G0,
    ST_G1,
    ST_G2,
    ST_G3,
    ST_PICK,
    ST_A0,
    ST_A1,
    ST_A2,
    ST_A3,
    ST_QRD,
    ST_SUM,
    ST_MULA,
    ST_WRITE,
    ST_OUT
  } qlpt_state_t;

  // Integer log2 in Q16.16 by repeated squaring, truncating.
  function automatic logic [31:0] log2_q16(input logic [31:0] n);
    logic [31:0] k;
    logic [63:0] m;
    logic [31:0] r;
    int i;
    int b;
    k = '0;
    for (i = 0; i < 30; i++) begin
      if ((n >> (k + 32'd1)) != 32'd0) begin
        k = k + 32'd1;
      end
    end
    m = {32'd0, n} << (32'd30 - k);
    r = k << 16;
    for (b = 15; b >= 0; b--) begin
      m = (m * m) >> 30;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        r = r | (32'd1 << b);
      end
    end
    return r;
  endfunction

  // Step count above which a draw d is greedy.
  function automatic logic [THR_ENTRIES*THR_W-1:0] greedy_table(input int steps);
    logic [THR_ENTRIES*THR_W-1:0] tbl;
    logic [31:0] top;
    logic [31:0] low;
    logic [31:0] l;
    logic [63:0] v;
    int d;
    tbl = '0;
    top = log2_q16(32'd100);
    for (d = 0; d < DRAW_LIMIT; d++) begin
      low = log2_q16(32'(DRAW_LIMIT - d));
      l = (top > low) ? (top - low) : 32'd0;
      v = (64'(steps) * 64'(LN2_Q16) * 64'(l)) >> 32;
      tbl[d*THR_W +: THR_W] = v[THR_W-1:0];
    end
    return tbl;
  endfunction

endpackage

`default_nettype wire

// ===== sv/qlpt_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Q-learning position tuner channels
// Valid/ready channels for the measurement items and the result items.
// ----------------------------------------------------------------------------
interface qlpt_in_if;
  logic                             valid;
  logic                             ready;
  logic [qlpt_pkg::PERF_W-1:0]      performance;
  logic [qlpt_pkg::EXPLORE_W-1:0]   explore_draw;
  logic [qlpt_pkg::ACT_DRAW_W-1:0]  action_draw;

  modport source(output valid, output performance, output explore_draw,
                 output action_draw, input ready);
  modport sink(input valid, input performance, input explore_draw,
               input action_draw, output ready);
endinterface

interface qlpt_out_if;
  logic                            valid;
  logic                            ready;
  logic [qlpt_pkg::ACT_W-1:0]      action;
  logic [qlpt_pkg::POS_OUT_W-1:0]  position;

  modport source(output valid, output action, output position, input ready);
  modport sink(input valid, input action, input position, output ready);
endinterface

`default_nettype wire

// ===== sv/qlpt_qtable.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Q-table storage
// Single write port, single registered read port. Per-entry valid bits make
// unwritten entries read as the initial value; a bulk clear reloads them all.
// ----------------------------------------------------------------------------
module qlpt_qtable #(
  parameter int DEPTH = 3 * qlpt_pkg::NUM_POSITIONS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic [$clog2(DEPTH)-1:0]          rd_addr,
  output logic signed [qlpt_pkg::Q_W-1:0]        rd_q,
  input  wire logic                              wr_en,
  input  wire logic [$clog2(DEPTH)-1:0]          wr_addr,
  input  wire logic signed [qlpt_pkg::Q_W-1:0]   wr_data,
  input  wire logic                              clear_all
);

  logic signed [qlpt_pkg::Q_W-1:0] mem [DEPTH];
  logic signed [qlpt_pkg::Q_W-1:0] rd_data_r;
  logic                            rd_hit_r;
  logic [DEPTH-1:0]                valid_r;

  // Storage array and registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
    rd_hit_r  <= valid_r[rd_addr];
  end

  // Valid bits: cleared at reset and on a reload, set on a write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (clear_all) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  // An entry not written since the last reload reads as the initial value.
  assign rd_q = rd_hit_r ? rd_data_r : qlpt_pkg::TABLE_INIT;

endmodule

`default_nettype wire

// ===== sv/q_learning_position_tuner.sv =====
`timescale 1ns / 1ps
`default_nettype none
// The block takes no new item until the result of the last one is taken;
// the sequencer walks the single read port of the Q table (seven reads per
// item) and the one shared multiplier (used twice per item) in turn.
// Reset: synchronous, active low; the Q table reads 10.0 at once through its
// valid bits, so no clearing pass is needed and the block is ready right away.
// ----------------------------------------------------------------------------
// Q-learning position tuner
// Tabular Q-learning with epsilon-greedy action choice over a row of
// positions, built as a small sequencer around one compare unit and one
// multiplier.
// ----------------------------------------------------------------------------
module q_learning_position_tuner #(
  parameter int NUM_POSITIONS = qlpt_pkg::NUM_POSITIONS_DEF,
  parameter int EXPLORE_STEPS = qlpt_pkg::EXPLORE_STEPS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  qlpt_in_if.sink                               in_item,
  qlpt_out_if.source                            out_item,
  input  wire logic                             cfg_we,
  input  wire logic [qlpt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [qlpt_pkg::CFG_W-1:0]       cfg_data
);

  localparam int DEPTH  = 3 * NUM_POSITIONS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int POS_W  = $clog2(NUM_POSITIONS);
  localparam logic [POS_W-1:0] POS_LAST  = POS_W'(NUM_POSITIONS - 1);
  localparam logic [POS_W-1:0] POS_RESET = POS_W'((NUM_POSITIONS > 2) ? 2 : NUM_POSITIONS - 1);
  localparam int MUL_A_W = 35;
  localparam int PROD_W  = MUL_A_W + 17;
  localparam logic [qlpt_pkg::THR_ENTRIES*qlpt_pkg::THR_W-1:0] GREEDY_TBL =
    qlpt_pkg::greedy_table(EXPLORE_STEPS);

  // Table entry address of action j at position p.
  function automatic logic [ADDR_W-1:0] entry_addr(input logic [POS_W-1:0] p,
                                                   input logic [1:0] j);
    return ADDR_W'(p) * ADDR_W'(3) + ADDR_W'(j);
  endfunction

  // Whether action j keeps position p inside the range.
  function automatic logic act_allowed(input logic [POS_W-1:0] p, input logic [1:0] j);
    logic ok;
    ok = 1'b0;
    if (j == qlpt_pkg::ACT_STAY) begin
      ok = 1'b1;
    end else if (j == qlpt_pkg::ACT_UP) begin
      ok = (p != POS_LAST);
    end else if (j == qlpt_pkg::ACT_DOWN) begin
      ok = (p != '0);
    end
    return ok;
  endfunction

  // Exploratory pick: draw modulo the number of allowed actions.
  function automatic logic [1:0] explore_pick(input logic [2:0] ad, input logic up_ok,
                                              input logic dn_ok);
    logic [1:0] idx;
    logic [1:0] act;
    idx = 2'd0;
    if (up_ok && dn_ok) begin
      unique case (ad)
        3'd0, 3'd3, 3'd6: idx = 2'd0;
        3'd1, 3'd4, 3'd7: idx = 2'd1;
        default:          idx = 2'd2;
      endcase
    end else if (up_ok || dn_ok) begin
      idx = {1'b0, ad[0]};
    end
    priority if (idx == 2'd0) begin
      act = qlpt_pkg::ACT_STAY;
    end else if (idx == 2'd1) begin
      act = up_ok ? qlpt_pkg::ACT_UP : qlpt_pkg::ACT_DOWN;
    end else begin
      act = qlpt_pkg::ACT_DOWN;
    end
    return act;
  endfunction

  qlpt_pkg::qlpt_state_t state_r, state_nxt;

  // Configuration and persistent learning state.
  logic [qlpt_pkg::CFG_W-1:0]    gamma_r;
  logic [qlpt_pkg::CFG_W-1:0]    alpha_r;
  logic [POS_W-1:0]              pos_r;
  logic [qlpt_pkg::PERF_W-1:0]   prev_perf_r;
  logic [qlpt_pkg::STEP_W-1:0]   step_r;
  logic [qlpt_pkg::STEP_W-1:0]   step_nxt;

  // Per-item working registers.
  logic [qlpt_pkg::PERF_W-1:0]      perf_r;
  logic [qlpt_pkg::ACT_DRAW_W-1:0]  act_draw_r;
  logic                             greedy_r;
  logic [1:0]                       act_r;
  logic [POS_W-1:0]                 next_r;
  logic signed [qlpt_pkg::Q_W-1:0]  best_r;
  logic [1:0]                       arg_r;
  logic signed [qlpt_pkg::Q_W-1:0]  q_r;
  logic signed [MUL_A_W-1:0]        diff_r;
  logic signed [PROD_W-1:0]         prod_r;

  // Sequencer outputs.
  logic [ADDR_W-1:0]  rd_addr;
  logic               cmp_en;
  logic [1:0]         cmp_j;
  logic [POS_W-1:0]   cmp_pos;
  logic               mul_en;
  logic               mul_alpha;
  logic               wr_en;

  // Datapath signals.
  logic signed [qlpt_pkg::Q_W-1:0]  rd_q;
  logic [qlpt_pkg::THR_W-1:0]       thr;
  logic                             in_fire;
  logic                             out_fire;
  logic                             greedy_now;
  logic                             up_ok;
  logic                             dn_ok;
  logic [1:0]                       act_sel;
  logic signed [MUL_A_W-1:0]        mul_a;
  logic signed [16:0]               mul_b;
  logic signed [24:0]               reward;
  logic signed [33:0]               sample;
  logic signed [35:0]               alpha_term;
  logic signed [36:0]               upd_sum;
  logic signed [qlpt_pkg::Q_W-1:0]  upd_val;

  assign in_fire  = in_item.valid && in_item.ready;
  assign out_fire = out_item.valid && out_item.ready;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gamma_r <= qlpt_pkg::GAMMA_RESET;
      alpha_r <= qlpt_pkg::ALPHA_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        qlpt_pkg::CFG_DISCOUNT_GAIN: gamma_r <= cfg_data;
        qlpt_pkg::CFG_LEARNING_RATE: alpha_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Saturating step count and the greedy threshold test.
  assign step_nxt   = (step_r == qlpt_pkg::STEP_MAX) ? step_r : step_r + 16'd1;
  assign thr        = GREEDY_TBL[in_item.explore_draw * qlpt_pkg::THR_W +: qlpt_pkg::THR_W];
  assign greedy_now = (in_item.explore_draw < qlpt_pkg::EXPLORE_W'(qlpt_pkg::DRAW_LIMIT)) &&
                      ({1'b0, step_nxt} > thr);

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      qlpt_pkg::ST_IDLE:  if (in_fire) begin
                            state_nxt = qlpt_pkg::ST_G0;
                          end
      qlpt_pkg::ST_G0:    state_nxt = qlpt_pkg::ST_G1;
      qlpt_pkg::ST_G1:    state_nxt = qlpt_pkg::ST_G2;
      qlpt_pkg::ST_G2:    state_nxt = qlpt_pkg::ST_G3;
      qlpt_pkg::ST_G3:    state_nxt = qlpt_pkg::ST_PICK;
      qlpt_pkg::ST_PICK:  state_nxt = qlpt_pkg::ST_A0;
      qlpt_pkg::ST_A0:    state_nxt = qlpt_pkg::ST_A1;
      qlpt_pkg::ST_A1:    state_nxt = qlpt_pkg::ST_A2;
      qlpt_pkg::ST_A2:    state_nxt = qlpt_pkg::ST_A3;
      qlpt_pkg::ST_A3:    state_nxt = qlpt_pkg::ST_QRD;
      qlpt_pkg::ST_QRD:   state_nxt = qlpt_pkg::ST_SUM;
      qlpt_pkg::ST_SUM:   state_nxt = qlpt_pkg::ST_MULA;
      qlpt_pkg::ST_MULA:  state_nxt = qlpt_pkg::ST_WRITE;
      qlpt_pkg::ST_WRITE: state_nxt = qlpt_pkg::ST_OUT;
      qlpt_pkg::ST_OUT:   if (out_fire) begin
                            state_nxt = qlpt_pkg::ST_IDLE;
                          end
      default:            state_nxt = qlpt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= qlpt_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Sequencer outputs: read address, compare step, multiplier use, table write and handshakes.
  always_comb begin
    rd_addr        = entry_addr(pos_r, qlpt_pkg::ACT_STAY);
    cmp_en         = 1'b0;
    cmp_j          = qlpt_pkg::ACT_STAY;
    cmp_pos        = pos_r;
    mul_en         = 1'b0;
    mul_alpha      = 1'b0;
    wr_en          = 1'b0;
    in_item.ready  = 1'b0;
    out_item.valid = 1'b0;
    unique case (state_r)
      qlpt_pkg::ST_IDLE:  in_item.ready = 1'b1;
      qlpt_pkg::ST_G0:    rd_addr = entry_addr(pos_r, qlpt_pkg::ACT_STAY);
      qlpt_pkg::ST_G1: begin
        rd_addr = entry_addr(pos_r, qlpt_pkg::ACT_UP);
        cmp_en  = 1'b1;
        cmp_j   = qlpt_pkg::ACT_STAY;
      end
      qlpt_pkg::ST_G2: begin
        rd_addr = entry_addr(pos_r, qlpt_pkg::ACT_DOWN);
        cmp_en  = 1'b1;
        cmp_j   = qlpt_pkg::ACT_UP;
      end
      qlpt_pkg::ST_G3: begin
        cmp_en = 1'b1;
        cmp_j  = qlpt_pkg::ACT_DOWN;
      end
      qlpt_pkg::ST_PICK:  ;
      qlpt_pkg::ST_A0:    rd_addr = entry_addr(next_r, qlpt_pkg::ACT_STAY);
      qlpt_pkg::ST_A1: begin
        rd_addr = entry_addr(next_r, qlpt_pkg::ACT_UP);
        cmp_en  = 1'b1;
        cmp_j   = qlpt_pkg::ACT_STAY;
        cmp_pos = next_r;
      end
      qlpt_pkg::ST_A2: begin
        rd_addr = entry_addr(next_r, qlpt_pkg::ACT_DOWN);
        cmp_en  = 1'b1;
        cmp_j   = qlpt_pkg::ACT_UP;
        cmp_pos = next_r;
      end
      qlpt_pkg::ST_A3: begin
        cmp_en  = 1'b1;
        cmp_j   = qlpt_pkg::ACT_DOWN;
        cmp_pos = next_r;
      end
      qlpt_pkg::ST_QRD: begin
        rd_addr = entry_addr(pos_r, act_r);
        mul_en  = 1'b1;
      end
      qlpt_pkg::ST_SUM:   ;
      qlpt_pkg::ST_MULA: begin
        mul_en    = 1'b1;
        mul_alpha = 1'b1;
      end
      qlpt_pkg::ST_WRITE: wr_en = 1'b1;
      qlpt_pkg::ST_OUT:   out_item.valid = 1'b1;
      default:            ;
    endcase
  end

  // Q table.
  qlpt_qtable #(
    .DEPTH(DEPTH)
  ) u_qtable (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_addr  (rd_addr),
    .rd_q     (rd_q),
    .wr_en    (wr_en),
    .wr_addr  (entry_addr(pos_r, act_r)),
    .wr_data  (upd_val),
    .clear_all(wr_en && (step_r == qlpt_pkg::RELOAD_STEP))
  );

  // Shared compare unit: running maximum over the allowed actions, lowest
  // action number wins a tie.
  always_ff @(posedge clk) begin
    if (cmp_en) begin
      if (cmp_j == qlpt_pkg::ACT_STAY) begin
        best_r <= rd_q;
        arg_r  <= qlpt_pkg::ACT_STAY;
      end else if (act_allowed(cmp_pos, cmp_j) && (rd_q > best_r)) begin
        best_r <= rd_q;
        arg_r  <= cmp_j;
      end
    end
  end

  // Action choice and next position.
  assign up_ok   = act_allowed(pos_r, qlpt_pkg::ACT_UP);
  assign dn_ok   = act_allowed(pos_r, qlpt_pkg::ACT_DOWN);
  assign act_sel = greedy_r ? arg_r : explore_pick(act_draw_r, up_ok, dn_ok);

  // Shared multiplier: gamma times the look-ahead maximum, then alpha times
  // the error term. Products are floored by taking the bits above 16.
  assign mul_a = mul_alpha ? diff_r : MUL_A_W'(best_r);
  assign mul_b = $signed({1'b0, (mul_alpha ? alpha_r : gamma_r)});

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_r <= mul_a * mul_b;
    end
  end

  // Reward plus discounted look-ahead, and the updated entry with saturation.
  assign reward     = $signed({1'b0, perf_r}) - $signed({1'b0, prev_perf_r});
  assign sample     = 34'(reward) + prod_r[49:16];
  assign alpha_term = prod_r[PROD_W-1:16];
  assign upd_sum    = 37'(q_r) + 37'(alpha_term);

  always_comb begin
    if (upd_sum > 37'sh0_7FFF_FFFF) begin
      upd_val = 32'sh7FFF_FFFF;
    end else if (upd_sum < -37'sh0_8000_0000) begin
      upd_val = -32'sh8000_0000;
    end else begin
      upd_val = upd_sum[qlpt_pkg::Q_W-1:0];
    end
  end

  // Per-item working registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      perf_r     <= in_item.performance;
      act_draw_r <= in_item.action_draw;
      greedy_r   <= greedy_now;
    end
    if (state_r == qlpt_pkg::ST_PICK) begin
      act_r <= act_sel;
      unique case (act_sel)
        qlpt_pkg::ACT_UP:   next_r <= pos_r + POS_W'(1);
        qlpt_pkg::ACT_DOWN: next_r <= pos_r - POS_W'(1);
        default:            next_r <= pos_r;
      endcase
    end
    if (state_r == qlpt_pkg::ST_SUM) begin
      q_r    <= rd_q;
      diff_r <= 35'(sample) - 35'(rd_q);
    end
  end

  // Persistent state: step count at accept, position and performance at
  // the table update.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '0;
      pos_r       <= POS_RESET;
      prev_perf_r <= '0;
    end else begin
      if (in_fire) begin
        step_r <= step_nxt;
      end
      if (wr_en) begin
        pos_r       <= next_r;
        prev_perf_r <= perf_r;
      end
    end
  end

  // Result payload is held by the working registers until taken.
  assign out_item.action   = act_r;
  assign out_item.position = qlpt_pkg::POS_OUT_W'(next_r);

  // Assertions.
  a_busy_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_item.ready && out_item.valid))
    else $error("input ready while a result is pending");

  a_write_then_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == qlpt_pkg::ST_WRITE) |=> out_item.valid)
    else $error("table update not followed by a result");

  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_LAST)
    else $error("position outside the range");

  a_act_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_item.valid |-> (act_r == qlpt_pkg::ACT_STAY || act_r == qlpt_pkg::ACT_UP ||
                        act_r == qlpt_pkg::ACT_DOWN))
    else $error("illegal action code on result");

endmodule

`default_nettype wire

// ===== tb/tb_q_learning_position_tuner.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Q-learning position tuner testbench
// Sends measurement items to the tuner under random sender bursts and
// receiver stalls. A behavioral copy of the learning rule (Q table, step
// count, epsilon threshold table, saturating update) predicts the action
// and the new position of every item, and each result is checked against
// the oldest prediction. Phases cover the table reload after the second
// step, the position edges, extreme gains, saturation and random traffic.
// ----------------------------------------------------------------------------
module tb_q_learning_position_tuner;
  import qlpt_pkg::*;

  localparam int NPOS       = NUM_POSITIONS_DEF;
  localparam int EXPL       = EXPLORE_STEPS_DEF;
  localparam int HALF_CLK   = 10;
  localparam int SETTLE     = 20;
  localparam int IDLE_LIMIT = 2000;
  localparam int MAX_PRINTS = 40;
  localparam longint Q_MAX  = 64'sd2147483647;
  localparam longint Q_MIN  = -64'sd2147483648;

  typedef struct packed {
    logic [ACT_W-1:0]     action;
    logic [POS_OUT_W-1:0] position;
  } move_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  qlpt_in_if  in_ch();
  qlpt_out_if out_ch();

  q_learning_position_tuner #(
    .NUM_POSITIONS(NPOS),
    .EXPLORE_STEPS(EXPL)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_item(in_ch),
    .out_item(out_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Tuner state as the testbench sees it.
  logic signed [Q_W-1:0] q_value [NPOS*3];
  int unsigned tuner_pos;
  logic [PERF_W-1:0] last_perf;
  int unsigned step_ct;
  logic [CFG_W-1:0] gamma_q;
  logic [CFG_W-1:0] alpha_q;
  longint unsigned greedy_floor [DRAW_LIMIT];

  move_t expected_moves [$];
  int errors = 0;
  int burst_left = 0;
  bit tx_free = 1'b0;
  bit rx_free = 1'b0;
  int idle_ct = 0;

  always #(HALF_CLK) clk = ~clk;

  // Integer log2 in Q16.16 by repeated squaring, truncating.
  function automatic int unsigned log2_fix(int unsigned n);
    int unsigned k;
    longint unsigned m;
    int unsigned r;
    int b;
    k = 0;
    while (k < 30 && (n >> (k + 1)) != 0) k++;
    m = longint'(n) << (30 - k);
    r = k << 16;
    for (b = 15; b >= 0; b--) begin
      m = (m * m) >> 30;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        r = r | (32'd1 << b);
      end
    end
    return r;
  endfunction

  // Product with a Q0.16 gain, floored toward minus infinity.
  function automatic longint scale_q16(longint a, logic [CFG_W-1:0] g);
    longint unsigned mag;
    if (a >= 0) return longint'((longint'(a) * longint'(g)) >> 16);
    mag = longint'(-a);
    return -longint'((mag * longint'(g) + 64'd65535) >> 16);
  endfunction

  function automatic logic signed [Q_W-1:0] best_value(int unsigned p);
    logic signed [Q_W-1:0] v;
    v = q_value[p*3];
    if (p + 1 < NPOS && q_value[p*3+1] > v) v = q_value[p*3+1];
    if (p > 0 && q_value[p*3+2] > v) v = q_value[p*3+2];
    return v;
  endfunction

  function automatic void reload_table();
    for (int i = 0; i < NPOS * 3; i++) q_value[i] = TABLE_INIT;
  endfunction

  function automatic void reset_tuner_model();
    int unsigned top;
    int unsigned low;
    longint unsigned l;
    reload_table();
    tuner_pos = 2;
    last_perf = '0;
    step_ct = 0;
    gamma_q = GAMMA_RESET;
    alpha_q = ALPHA_RESET;
    top = log2_fix(DRAW_LIMIT);
    for (int d = 0; d < DRAW_LIMIT; d++) begin
      low = log2_fix(DRAW_LIMIT - d);
      l = (top > low) ? longint'(top - low) : 64'd0;
      greedy_floor[d] = (longint'(EXPL) * longint'(LN2_Q16) * l) >> 32;
    end
  endfunction

  // One learning step: choose the action, update the table, move.
  function automatic move_t predict_tuner_step(logic [PERF_W-1:0] perf,
                                               logic [EXPLORE_W-1:0] ed,
                                               logic [ACT_DRAW_W-1:0] ad);
    int unsigned base;
    int unsigned next;
    int unsigned n;
    bit up_ok;
    bit dn_ok;
    logic [ACT_W-1:0] act;
    logic [ACT_W-1:0] opts [3];
    logic signed [Q_W-1:0] bv;
    longint reward;
    longint sample;
    longint q;
    longint upd;
    move_t res;
    if (step_ct < STEP_MAX) step_ct++;
    base = tuner_pos * 3;
    up_ok = (tuner_pos + 1 < NPOS);
    dn_ok = (tuner_pos > 0);
    if (ed < DRAW_LIMIT && longint'(step_ct) > greedy_floor[ed]) begin
      // Greedy: lowest action number wins a tie.
      bv = q_value[base];
      act = ACT_STAY;
      if (up_ok && q_value[base+1] > bv) begin
        bv = q_value[base+1];
        act = ACT_UP;
      end
      if (dn_ok && q_value[base+2] > bv) act = ACT_DOWN;
    end else begin
      // Exploration: the draw modulo the allowed count picks from the list.
      n = 0;
      opts[n++] = ACT_STAY;
      if (up_ok) opts[n++] = ACT_UP;
      if (dn_ok) opts[n++] = ACT_DOWN;
      act = opts[ad % n];
    end
    next = tuner_pos;
    if (act == ACT_UP) next = tuner_pos + 1;
    else if (act == ACT_DOWN) next = tuner_pos - 1;
    reward = longint'(perf) - longint'(last_perf);
    sample = reward + scale_q16(longint'(best_value(next)), gamma_q);
    q = longint'(q_value[base+act]);
    upd = q + scale_q16(sample - q, alpha_q);
    if (upd > Q_MAX) upd = Q_MAX;
    else if (upd < Q_MIN) upd = Q_MIN;
    q_value[base+act] = upd[Q_W-1:0];
    tuner_pos = next;
    last_perf = perf;
    if (step_ct == RELOAD_STEP) reload_table();
    res.action = act;
    res.position = next[POS_OUT_W-1:0];
    return res;
  endfunction

  // Action draw that makes an exploring step take the given action.
  function automatic logic [ACT_DRAW_W-1:0] draw_for(logic [ACT_W-1:0] act);
    int unsigned n;
    int unsigned idx;
    bit up_ok;
    up_ok = (tuner_pos + 1 < NPOS);
    n = 1 + (up_ok ? 1 : 0) + ((tuner_pos > 0) ? 1 : 0);
    idx = 0;
    if (act == ACT_UP) idx = 1;
    else if (act == ACT_DOWN) idx = up_ok ? 2 : 1;
    if (idx + n <= 5 && $urandom_range(0, 1) == 1) idx = idx + n;
    return idx[ACT_DRAW_W-1:0];
  endfunction

  task automatic report_bad(string what, int exp_v, int act_v);
    errors++;
    if (errors <= MAX_PRINTS)
      $display("%0t ns: %s expected %0d actual %0d", $time, what, exp_v, act_v);
  endtask

  // Send one measurement item; between bursts the sender may pause, unless tx_free is set.
  task automatic send_measurement(logic [PERF_W-1:0] perf,
                                  logic [EXPLORE_W-1:0] ed,
                                  logic [ACT_DRAW_W-1:0] ad);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
      if (!tx_free && gap > 0) begin
        @(negedge clk);
        in_ch.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.performance <= perf;
    in_ch.explore_draw <= ed;
    in_ch.action_draw <= ad;
    do @(posedge clk); while (!in_ch.ready);
    expected_moves.push_back(predict_tuner_step(perf, ed, ad));
  endtask

  // Random item: performance mostly random, some small changes and some extremes.
  task automatic send_random_measurement();
    logic [PERF_W-1:0] perf;
    logic [EXPLORE_W-1:0] ed;
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) perf = '1;
    else if (r == 1) perf = '0;
    else if (r <= 4) perf = last_perf + PERF_W'($urandom_range(0, 8191)) - PERF_W'(4096);
    else perf = PERF_W'($urandom);
    r = $urandom_range(0, 9);
    if (r == 0) ed = EXPLORE_W'(DRAW_LIMIT);
    else if (r == 1) ed = '0;
    else if (r == 2) ed = EXPLORE_W'(DRAW_LIMIT - 1);
    else ed = EXPLORE_W'($urandom_range(0, DRAW_LIMIT));
    send_measurement(perf, ed, ACT_DRAW_W'($urandom_range(0, 5)));
  endtask

  // Stop sending and wait until every predicted result has come back.
  task automatic wait_until_settled();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (expected_moves.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_DISCOUNT_GAIN) gamma_q = value;
    else alpha_q = value;
  endtask

  task automatic set_gains(logic [CFG_W-1:0] g, logic [CFG_W-1:0] a);
    wait_until_settled();
    write_reg(CFG_DISCOUNT_GAIN, g);
    write_reg(CFG_LEARNING_RATE, a);
  endtask

  // The table reload after the second step, right after reset.
  task automatic test_table_reload();
    send_measurement('1, EXPLORE_W'(DRAW_LIMIT), draw_for(ACT_STAY));
    send_measurement('0, EXPLORE_W'(DRAW_LIMIT), draw_for(ACT_UP));
    send_measurement(PERF_W'(1), '0, '0);
  endtask

  // Walk to both ends of the position range, with greedy steps and
  // forbidden moves tried at the ends.
  task automatic test_position_edges();
    while (tuner_pos > 0)
      send_measurement(PERF_W'($urandom), EXPLORE_W'(DRAW_LIMIT), draw_for(ACT_DOWN));
    send_measurement('1, EXPLORE_W'(DRAW_LIMIT), draw_for(ACT_STAY));
    send_measurement('0, EXPLORE_W'(DRAW_LIMIT - 1), ACT_DRAW_W'(5));
    send_measurement('1, '0, '0);
    while (tuner_pos < NPOS - 1)
      send_measurement(PERF_W'($urandom), EXPLORE_W'(DRAW_LIMIT), draw_for(ACT_UP));
    send_measurement('0, EXPLORE_W'(DRAW_LIMIT), ACT_DRAW_W'(4));
    send_measurement('1, '0, ACT_DRAW_W'(3));
    send_measurement('0, EXPLORE_W'(DRAW_LIMIT), draw_for(ACT_DOWN));
  endtask

  // Extreme gain settings, each with a block of random items.
  task automatic test_gain_extremes();
    logic [CFG_W-1:0] g_set [4] = '{16'd0, 16'hFFFF, 16'd0, 16'hFFFF};
    logic [CFG_W-1:0] a_set [4] = '{16'd0, 16'hFFFF, 16'hFFFF, 16'd0};
    for (int s = 0; s < 4; s++) begin
      set_gains(g_set[s], a_set[s]);
      repeat (90) send_random_measurement();
    end
  endtask

  // Full gains and alternating extreme performance drive the entries
  // toward the saturation limit.
  task automatic test_saturation();
    set_gains(16'hFFFF, 16'hFFFF);
    for (int i = 0; i < 200; i++)
      send_measurement((i % 2 == 0) ? '1 : '0, EXPLORE_W'($urandom_range(0, DRAW_LIMIT)),
                       ACT_DRAW_W'($urandom_range(0, 5)));
  endtask

  // Reset gains first, then random gains, with random traffic; one phase
  // without any idling, and the sender pauses once until every result is back.
  task automatic test_random_traffic();
    for (int s = 0; s < 6; s++) begin
      if (s == 0) set_gains(GAMMA_RESET, ALPHA_RESET);
      else set_gains(CFG_W'($urandom), CFG_W'($urandom));
      tx_free = (s == 3);
      rx_free = (s == 3);
      for (int i = 0; i < 210; i++) begin
        if (s == 2 && i == 100) wait_until_settled();
        send_random_measurement();
      end
    end
    tx_free = 1'b0;
    rx_free = 1'b0;
  endtask

  // Receiver: ready with random stalls of its own.
  initial begin
    int stall_left;
    stall_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_free || stall_left == 0) begin
        out_ch.ready <= 1'b1;
        if (!rx_free && $urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 20);
      end else begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end
    end
  end

  // Result check against the oldest prediction.
  always @(posedge clk) begin
    move_t exp_m;
    if (out_ch.valid && out_ch.ready) begin
      if (expected_moves.size() == 0) begin
        report_bad("unexpected result, action", -1, out_ch.action);
      end else begin
        exp_m = expected_moves.pop_front();
        if (out_ch.action !== exp_m.action)
          report_bad("action", exp_m.action, out_ch.action);
        if (out_ch.position !== exp_m.position)
          report_bad("position", exp_m.position, out_ch.position);
      end
    end
  end

  // Watchdog on cycles with no item accepted on either side.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_ct <= 0;
    else idle_ct <= idle_ct + 1;
    if (idle_ct >= IDLE_LIMIT) begin
      $display("q_learning_position_tuner: mismatch");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.performance = '0;
    in_ch.explore_draw = '0;
    in_ch.action_draw = '0;
    reset_tuner_model();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_table_reload();
    test_position_edges();
    test_gain_extremes();
    test_saturation();
    test_random_traffic();

    wait_until_settled();
    if (errors == 0) begin
      $display("q_learning_position_tuner: match");
    end else begin
      $display("q_learning_position_tuner: mismatch");
    end
    $finish;
  end

endmodule
